// ===== rtl/bcu_pkg.sv =====
// Package for the binomial coefficient unit: field widths, status codes and
// sequencer states. No dependencies.
package bcu_pkg;

  localparam int unsigned N_W      = 6;             // n_total, m_chosen
  localparam int unsigned COEF_W   = 32;            // coefficient
  localparam int unsigned FACT_W   = N_W;           // multiplier factor and divisor
  localparam int unsigned PROD_W   = COEF_W + FACT_W; // product / dividend
  localparam int unsigned CNT_W    = $clog2(PROD_W);
  localparam int unsigned MAX_N_DEF = 32;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_M_GT_N = 2'd1,
    ST_N_BIG  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

endpackage

// ===== rtl/binomial_coefficient_unit.sv =====
// Binomial coefficient unit: C(n,m) by the multiplicative rule on one shared
// adder, time-shared between a shift-add multiply and a restoring divide.
// Depends on bcu_pkg.
//
//  channel | dir | tdata                                 | tuser
//  s_      | in  | [5:0] n_total, [11:6] m_chosen, pad   | -
//  m_      | out | [31:0] coefficient                    | [1:0] status
//
// One item takes k = min(m, n-m) rounds (at most 16); each round is
// 6 multiply steps and 38 divide steps on the adder.
// Errors and k = 0 skip the rounds and go straight to finish. s_tready is high only while idle.
// The result sits in an output register, so a new beat is taken while it waits.
// rst is synchronous and clears the sequencer and the output valid.
module binomial_coefficient_unit #(
  parameter int unsigned MAX_N = bcu_pkg::MAX_N_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [15:0]                s_tdata,   // [5:0] n_total, [11:6] m_chosen
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [bcu_pkg::COEF_W-1:0] m_tdata,   // [31:0] coefficient
  output logic [1:0]                 m_tuser    // [1:0] status
);

  localparam int unsigned N_W    = bcu_pkg::N_W;
  localparam int unsigned COEF_W = bcu_pkg::COEF_W;
  localparam int unsigned FACT_W = bcu_pkg::FACT_W;
  localparam int unsigned PROD_W = bcu_pkg::PROD_W;
  localparam int unsigned CNT_W  = bcu_pkg::CNT_W;

  bcu_pkg::state_t  state, state_next;
  bcu_pkg::status_t status, status_next;
  logic [COEF_W-1:0] res, res_next;
  logic [PROD_W-1:0] prod, prod_next;
  logic [FACT_W:0]   rem, rem_next;
  logic [FACT_W-1:0] mult, mult_next;
  logic [N_W-1:0]    base, base_next;
  logic [N_W-1:0]    k, k_next;
  logic [N_W-1:0]    i_cnt, i_cnt_next;
  logic [CNT_W-1:0]  cnt, cnt_next;

  logic [COEF_W-1:0] out_coef;
  bcu_pkg::status_t  out_status;
  logic              out_valid;
  logic              out_load;

  // input decode
  logic [N_W-1:0] n_in, m_in, nm_diff, k_in;
  assign n_in    = s_tdata[N_W-1:0];
  assign m_in    = s_tdata[2*N_W-1:N_W];
  assign nm_diff = n_in - m_in;
  assign k_in    = (m_in < nm_diff) ? m_in : nm_diff;

  // shared adder
  logic [PROD_W-1:0] alu_a, alu_b;
  logic              alu_cin;
  logic [PROD_W:0]   alu_sum;
  logic [FACT_W:0]   rem_sh;
  logic              div_ge;

  assign rem_sh  = {rem[FACT_W-1:0], prod[PROD_W-1]};
  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + (PROD_W+1)'(alu_cin);
  assign div_ge  = alu_sum[PROD_W];   // carry out: rem_sh >= i

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    unique case (state)
      bcu_pkg::S_MUL: begin
        alu_a = {prod[PROD_W-2:0], 1'b0};
        alu_b = mult[FACT_W-1] ? PROD_W'(res) : '0;
      end
      bcu_pkg::S_DIV: begin
        alu_a   = PROD_W'(rem_sh);
        alu_b   = ~PROD_W'(i_cnt);
        alu_cin = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign s_tready = (state == bcu_pkg::S_IDLE);
  assign out_load = (state == bcu_pkg::S_FINISH) && (!out_valid || m_tready);

  always_comb begin
    logic [PROD_W-1:0] quot;
    quot        = {prod[PROD_W-2:0], div_ge};
    state_next  = state;
    status_next = status;
    res_next    = res;
    prod_next   = prod;
    rem_next    = rem;
    mult_next   = mult;
    base_next   = base;
    k_next      = k;
    i_cnt_next  = i_cnt;
    cnt_next    = cnt;
    unique case (state)
      bcu_pkg::S_IDLE: begin
        if (s_tvalid) begin
          base_next  = n_in - k_in;
          k_next     = k_in;
          i_cnt_next = N_W'(1);
          mult_next  = FACT_W'(n_in - k_in + N_W'(1));
          prod_next  = '0;
          cnt_next   = '0;
          res_next   = COEF_W'(1);
          priority if (n_in > N_W'(MAX_N)) begin
            status_next = bcu_pkg::ST_N_BIG;
            res_next    = '0;
            state_next  = bcu_pkg::S_FINISH;
          end else if (m_in > n_in) begin
            status_next = bcu_pkg::ST_M_GT_N;
            res_next    = '0;
            state_next  = bcu_pkg::S_FINISH;
          end else if (k_in == '0) begin
            status_next = bcu_pkg::ST_OK;
            state_next  = bcu_pkg::S_FINISH;
          end else begin
            status_next = bcu_pkg::ST_OK;
            state_next  = bcu_pkg::S_MUL;
          end
        end
      end
      bcu_pkg::S_MUL: begin
        // msb-first shift-add: prod = res * factor
        prod_next = alu_sum[PROD_W-1:0];
        mult_next = {mult[FACT_W-2:0], 1'b0};
        cnt_next  = cnt + CNT_W'(1);
        if (cnt == CNT_W'(FACT_W-1)) begin
          cnt_next   = '0;
          rem_next   = '0;
          state_next = bcu_pkg::S_DIV;
        end
      end
      bcu_pkg::S_DIV: begin
        // restoring divide by i, quotient shifts in at the bottom of prod
        rem_next  = div_ge ? alu_sum[FACT_W:0] : rem_sh;
        prod_next = quot;
        cnt_next  = cnt + CNT_W'(1);
        if (cnt == CNT_W'(PROD_W-1)) begin
          cnt_next  = '0;
          res_next  = quot[COEF_W-1:0];
          prod_next = '0;
          if (i_cnt == k) begin
            state_next = bcu_pkg::S_FINISH;
          end else begin
            i_cnt_next = i_cnt + N_W'(1);
            mult_next  = FACT_W'(base + i_cnt + N_W'(1));
            state_next = bcu_pkg::S_MUL;
          end
        end
      end
      bcu_pkg::S_FINISH: begin
        if (out_load) begin
          state_next = bcu_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bcu_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcu_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
    res    <= res_next;
    prod   <= prod_next;
    rem    <= rem_next;
    mult   <= mult_next;
    base   <= base_next;
    k      <= k_next;
    i_cnt  <= i_cnt_next;
    cnt    <= cnt_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_coef   <= res;
      out_status <= status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_coef;
  assign m_tuser  = out_status;

endmodule

// ===== rtl/bcu_checker.sv =====
// Port-level checks for the binomial coefficient unit, bound to the top level.
// Depends on bcu_pkg.
module bcu_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [bcu_pkg::COEF_W-1:0] m_tdata,
  input logic [1:0]                 m_tuser
);

  // an error beat carries a zero coefficient
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != bcu_pkg::ST_OK) |-> m_tdata == '0)
    else $error("error beat with nonzero coefficient");

  // C(n,m) is never zero for a good input
  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == bcu_pkg::ST_OK) |-> m_tdata != '0)
    else $error("ok beat with zero coefficient");

  // one item at a time: input closes right after a beat is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after accept");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind binomial_coefficient_unit bcu_checker u_bcu_checker (.*);
